/* hw/rtl/energy_meter_frame_receiver_defines.svh */
// assertion macros for the metering frame receiver
// no dependencies; taken in by files that carry assertions
`ifndef ENERGY_METER_FRAME_RECEIVER_DEFINES_SVH
`define ENERGY_METER_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define EMFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the following cycle
`define EMFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EMFR_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define EMFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/emfr_pkg.sv */
// shared constants, types and helpers of the metering frame receiver
// no dependencies
package emfr_pkg;

  localparam int unsigned FrameLen   = 24;
  localparam int unsigned PosW       = $clog2(FrameLen);
  localparam logic [7:0]  CheckByte  = 8'h5A;

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t CheckIndex = pos_t'(1);
  localparam pos_t SumFirst   = pos_t'(2);
  localparam pos_t SumLast    = pos_t'(22);
  localparam pos_t FlagIndex  = pos_t'(20);
  localparam pos_t LastPos    = pos_t'(FrameLen - 1);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHECK = 2'd1,
    STATUS_BAD_SUM   = 2'd2
  } status_t;

  // big-endian 24-bit register from three bytes
  function automatic logic [23:0] take24(input logic [7:0] hi, input logic [7:0] mid,
                                         input logic [7:0] lo);
    return {hi, mid, lo};
  endfunction

endpackage

/* hw/rtl/emfr_rx_if.sv */
// received-byte channel of the metering frame receiver
// no dependencies
interface emfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

/* hw/rtl/emfr_result_if.sv */
// result channel of the metering frame receiver
// depends on emfr_pkg
interface emfr_result_if;
  logic             valid;
  logic             ready;
  emfr_pkg::status_t status;
  logic [23:0]      voltage_param;
  logic [23:0]      voltage_data;
  logic [23:0]      current_param;
  logic [23:0]      current_data;
  logic [23:0]      power_param;
  logic [23:0]      power_data;
  logic [15:0]      pulse_count;
  logic [31:0]      pulse_overflows;
  logic             ever_valid;

  modport source (output valid, output status, output voltage_param, output voltage_data,
                  output current_param, output current_data, output power_param,
                  output power_data, output pulse_count, output pulse_overflows,
                  output ever_valid, input ready);
  modport sink   (input valid, input status, input voltage_param, input voltage_data,
                  input current_param, input current_data, input power_param,
                  input power_data, input pulse_count, input pulse_overflows,
                  input ever_valid, output ready);
endinterface

/* hw/rtl/energy_meter_frame_receiver.sv */
// metering frame receiver: checks 24-byte frames and latches meter registers
// depends on emfr_pkg, emfr_rx_if, emfr_result_if, energy_meter_frame_receiver_defines.svh
//
//   channel  dir  carries                               handshake
//   rx       in   rx_byte, frame_start                  valid/ready
//   result   out  status, stored registers, ever_valid  valid/ready
//
// one byte per cycle while the result is not stalled; a byte is held in the
// input register, handled from there; the 24th byte's result shows the cycle after.
// the stored meter registers double as the result register, so a new frame
// result waits only for the previous result to be taken.
// a stalled result holds the input register once it is full; nothing is dropped.
// rst is synchronous and clears position, sum, stored registers and the valid flags.
`include "energy_meter_frame_receiver_defines.svh"

module energy_meter_frame_receiver (
  input  logic                 clk,
  input  logic                 rst,
  emfr_rx_if.sink              rx,
  emfr_result_if.source        result
);
  import emfr_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       advance;

  // frame state
  pos_t       pos;
  logic [7:0] running_sum;
  logic [7:0] frame_buf [FrameLen];

  // stored registers, also the result payload
  logic        res_valid;
  status_t     res_status;
  logic [23:0] held_voltage_param;
  logic [23:0] held_voltage_data;
  logic [23:0] held_current_param;
  logic [23:0] held_current_data;
  logic [23:0] held_power_param;
  logic [23:0] held_power_data;
  logic [15:0] held_pulse_count;
  logic [31:0] overflow_counter;
  logic        seen_valid;

  logic       in_frame;
  logic       emit;
  logic       frame_ok;
  status_t    status_next;
  logic [7:0] flags;

  assign advance  = s1_valid && (!res_valid || result.ready);
  assign rx.ready = !s1_valid || advance;

  assign in_frame = !s1_start && (pos != '0);
  assign emit     = advance && in_frame && (pos == LastPos);
  assign flags    = frame_buf[FlagIndex];

  always_comb begin
    if (frame_buf[CheckIndex] != CheckByte) begin
      status_next = STATUS_BAD_CHECK;
    end else if (running_sum != s1_byte) begin
      status_next = STATUS_BAD_SUM;
    end else begin
      status_next = STATUS_OK;
    end
  end
  assign frame_ok = (status_next == STATUS_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte  <= rx.rx_byte;
      s1_start <= rx.frame_start;
    end
  end

  // frame buffer, no reset: only entries of the current frame are read
  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_start) begin
        frame_buf[0] <= s1_byte;
      end else if (pos != '0) begin
        frame_buf[pos] <= s1_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= '0;
    end else if (advance) begin
      if (s1_start) begin
        pos         <= pos_t'(1);
        running_sum <= '0;
      end else if (pos != '0) begin
        if (pos == LastPos) begin
          pos         <= '0;
          running_sum <= '0;
        end else begin
          pos <= pos + pos_t'(1);
          if (pos >= SumFirst && pos <= SumLast) begin
            running_sum <= running_sum + s1_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid          <= 1'b0;
      res_status         <= STATUS_OK;
      held_voltage_param <= '0;
      held_voltage_data  <= '0;
      held_current_param <= '0;
      held_current_data  <= '0;
      held_power_param   <= '0;
      held_power_data    <= '0;
      held_pulse_count   <= '0;
      overflow_counter   <= '0;
      seen_valid         <= 1'b0;
    end else begin
      if (emit) begin
        res_valid  <= 1'b1;
        res_status <= status_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (emit && frame_ok) begin
        held_voltage_param <= take24(frame_buf[2], frame_buf[3], frame_buf[4]);
        held_current_param <= take24(frame_buf[8], frame_buf[9], frame_buf[10]);
        held_power_param   <= take24(frame_buf[14], frame_buf[15], frame_buf[16]);
        if (flags[6]) begin
          held_voltage_data <= take24(frame_buf[5], frame_buf[6], frame_buf[7]);
        end
        if (flags[5]) begin
          held_current_data <= take24(frame_buf[11], frame_buf[12], frame_buf[13]);
        end
        if (flags[4]) begin
          held_power_data <= take24(frame_buf[17], frame_buf[18], frame_buf[19]);
        end
        held_pulse_count <= {frame_buf[21], frame_buf[22]};
        if (flags[7]) begin
          overflow_counter <= overflow_counter + 32'd1;
        end
        seen_valid <= 1'b1;
      end
    end
  end

  assign result.valid           = res_valid;
  assign result.status          = res_status;
  assign result.voltage_param   = held_voltage_param;
  assign result.voltage_data    = held_voltage_data;
  assign result.current_param   = held_current_param;
  assign result.current_data    = held_current_data;
  assign result.power_param     = held_power_param;
  assign result.power_data      = held_power_data;
  assign result.pulse_count     = held_pulse_count;
  assign result.pulse_overflows = overflow_counter;
  assign result.ever_valid      = seen_valid;

  `EMFR_ASSERT_SAME(a_ok_implies_valid, clk, rst, res_valid && res_status == STATUS_OK, seen_valid, "accepted frame without ever_valid")
  `EMFR_ASSERT_NEXT(a_seen_sticky, clk, rst, seen_valid, seen_valid, "ever_valid dropped")
  `EMFR_ASSERT_NEXT(a_ovf_only_on_ok, clk, rst, !(emit && frame_ok), $stable(overflow_counter), "overflow count moved without an accepted frame")
  `EMFR_ASSERT_SAME(a_emit_slot_free, clk, rst, emit, !res_valid || result.ready, "result overwritten before taken")

endmodule
